/* rtl/lru_pkg.sv */
`timescale 1ns / 1ps

package lru_pkg;

  localparam int MAX_FRAMES  = 8;
  localparam int PAGE_BITS   = 16;
  localparam int CFG_W       = 4;
  localparam int FAULT_W     = 32;
  localparam int FRAME_IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W      = FRAME_IDX_W;
  localparam int COUNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int LIM_W       = (CFG_W > COUNT_W) ? CFG_W : COUNT_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(MAX_FRAMES);

  typedef struct packed {
    logic                 valid;
    logic [PAGE_BITS-1:0] page;
    logic [RANK_W-1:0]    rank;
  } frame_entry_t;

  typedef struct packed {
    logic                   hit_found;
    logic [FRAME_IDX_W-1:0] hit_idx;
    logic [RANK_W-1:0]      hit_rank;
    logic                   victim_found;
    logic [FRAME_IDX_W-1:0] victim_idx;
    logic [RANK_W-1:0]      victim_rank;
    logic [PAGE_BITS-1:0]   victim_page;
    logic                   free_found;
    logic [FRAME_IDX_W-1:0] free_idx;
    logic [COUNT_W-1:0]     used;
  } scan_acc_t;

  typedef struct packed {
    logic                   en;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] idx;
    logic [RANK_W-1:0]      rank;
    logic [PAGE_BITS-1:0]   page;
  } frame_upd_t;

endpackage

/* rtl/lru_req_if.sv */
`timescale 1ns / 1ps

interface lru_req_if;
  import lru_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page;
  logic                 start_of_sequence;

  modport source (output valid, output page, output start_of_sequence, input ready);
  modport sink (input valid, input page, input start_of_sequence, output ready);
endinterface

/* rtl/lru_rsp_if.sv */
`timescale 1ns / 1ps

interface lru_rsp_if;
  import lru_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 evicted_valid;
  logic [PAGE_BITS-1:0] evicted_page;
  logic [FAULT_W-1:0]   fault_count;

  modport source (
    output valid, output hit, output evicted_valid, output evicted_page,
    output fault_count, input ready
  );
  modport sink (
    input valid, input hit, input evicted_valid, input evicted_page,
    input fault_count, output ready
  );
endinterface

/* rtl/lru_frame_store.sv */
`timescale 1ns / 1ps

module lru_frame_store import lru_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clear_i,
  input  logic [FRAME_IDX_W-1:0]  rd_idx_i,
  input  frame_upd_t              upd_i,
  output frame_entry_t            rd_o,
  output logic [MAX_FRAMES-1:0]   valid_o
);

  logic [PAGE_BITS-1:0] page_q  [MAX_FRAMES];
  logic [RANK_W-1:0]    rank_q  [MAX_FRAMES];
  logic [RANK_W-1:0]    rank_d  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;
  logic [MAX_FRAMES-1:0] valid_d;

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (clear_i) begin
        valid_d[i] = 1'b0;
        rank_d[i]  = '0;
      end else if (upd_i.en) begin
        if (upd_i.hit) begin
          // move the hit frame to the front, age the ones that were ahead of it
          if (upd_i.idx == FRAME_IDX_W'(i)) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && rank_q[i] < upd_i.rank) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
        end else begin
          if (upd_i.idx == FRAME_IDX_W'(i)) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && !upd_i.hit) begin
      page_q[upd_i.idx] <= upd_i.page;
    end
  end

  assign rd_o.valid = valid_q[rd_idx_i];
  assign rd_o.page  = page_q[rd_idx_i];
  assign rd_o.rank  = rank_q[rd_idx_i];
  assign valid_o    = valid_q;

endmodule

/* rtl/lru_scan_unit.sv */
`timescale 1ns / 1ps

module lru_scan_unit import lru_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    step_i,
  input  logic [FRAME_IDX_W-1:0]  idx_i,
  input  frame_entry_t            entry_i,
  input  logic [PAGE_BITS-1:0]    page_i,
  output scan_acc_t               acc_o
);

  scan_acc_t acc_q;
  scan_acc_t acc_d;

  always_comb begin
    acc_d = acc_q;
    if (start_i) begin
      acc_d = '0;
    end else if (step_i) begin
      if (entry_i.valid) begin
        acc_d.used = acc_q.used + COUNT_W'(1);
        if (!acc_q.hit_found && entry_i.page == page_i) begin
          acc_d.hit_found = 1'b1;
          acc_d.hit_idx   = idx_i;
          acc_d.hit_rank  = entry_i.rank;
        end
        // strict compare keeps the lowest index on a tie
        if (!acc_q.victim_found || entry_i.rank > acc_q.victim_rank) begin
          acc_d.victim_found = 1'b1;
          acc_d.victim_idx   = idx_i;
          acc_d.victim_rank  = entry_i.rank;
          acc_d.victim_page  = entry_i.page;
        end
      end else if (!acc_q.free_found) begin
        acc_d.free_found = 1'b1;
        acc_d.free_idx   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

/* rtl/lru_page_replacement.sv */
`timescale 1ns / 1ps
// channel   dir  handshake            payload
// req       in   req.valid/req.ready  page, start_of_sequence
// rsp       out  rsp.valid/rsp.ready  hit, evicted_valid, evicted_page, fault_count
// cfg       in   cfg_we_i             cfg_wdata_i = frames_in_use
//
// an item passes through acceptance, a scan of one frame per cycle through the
// shared match and victim compare unit, and an update that loads the result.
// req.ready is high only between items; a result waits in the output register,
// and the next item is taken while it waits.
// an update cycle stalls while the output register is still full and rsp.ready is low.
// reset is asynchronous, active low; it empties all frames at once, no clearing pass.

module lru_page_replacement import lru_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  lru_req_if.sink          req,
  lru_rsp_if.source        rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [FRAME_IDX_W-1:0] idx_q, idx_d;
  logic [CFG_W-1:0]       cfg_q;
  logic [PAGE_BITS-1:0]   page_q;
  logic [FAULT_W-1:0]     fault_q, fault_d, fault_next;
  logic                   out_valid_q, out_valid_d;
  logic                   out_hit_q, out_ev_valid_q;
  logic [PAGE_BITS-1:0]   out_ev_page_q;
  logic [FAULT_W-1:0]     out_fault_q;

  logic                   accept;
  logic                   load;
  logic                   use_free;
  logic [LIM_W-1:0]       limit;
  frame_entry_t           entry;
  scan_acc_t              acc;
  frame_upd_t             upd;
  logic [MAX_FRAMES-1:0]  valid_vec;

  assign req.ready = (state_q == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign load      = (state_q == ST_UPD) && (!out_valid_q || rsp.ready);

  // frame limit clamped into 1..MAX_FRAMES
  always_comb begin
    if (cfg_q == '0) begin
      limit = LIM_W'(1);
    end else if (LIM_W'(cfg_q) > LIM_W'(MAX_FRAMES)) begin
      limit = LIM_W'(MAX_FRAMES);
    end else begin
      limit = LIM_W'(cfg_q);
    end
  end

  assign use_free = acc.free_found && (LIM_W'(acc.used) < limit);

  always_comb begin
    upd.en   = load;
    upd.hit  = acc.hit_found;
    upd.rank = acc.hit_rank;
    upd.page = page_q;
    if (acc.hit_found) begin
      upd.idx = acc.hit_idx;
    end else if (use_free) begin
      upd.idx = acc.free_idx;
    end else begin
      upd.idx = acc.victim_idx;
    end
  end

  lru_frame_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (accept && req.start_of_sequence),
    .rd_idx_i (idx_q),
    .upd_i    (upd),
    .rd_o     (entry),
    .valid_o  (valid_vec)
  );

  lru_scan_unit u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .step_i  (state_q == ST_SCAN),
    .idx_i   (idx_q),
    .entry_i (entry),
    .page_i  (page_q),
    .acc_o   (acc)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (idx_q == FRAME_IDX_W'(MAX_FRAMES - 1)) begin
          state_d = ST_UPD;
        end else begin
          idx_d = idx_q + FRAME_IDX_W'(1);
        end
      end
      ST_UPD: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign fault_next = (fault_q == '1) ? fault_q : fault_q + FAULT_W'(1);

  always_comb begin
    fault_d = fault_q;
    if (accept && req.start_of_sequence) begin
      fault_d = '0;
    end else if (load && !acc.hit_found) begin
      fault_d = fault_next;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cfg_q       <= CFG_RESET;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= req.page;
    end
    if (load) begin
      out_hit_q      <= acc.hit_found;
      out_ev_valid_q <= !acc.hit_found && !use_free;
      out_ev_page_q  <= (!acc.hit_found && !use_free) ? acc.victim_page : '0;
      out_fault_q    <= fault_d;
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.hit           = out_hit_q;
  assign rsp.evicted_valid = out_ev_valid_q;
  assign rsp.evicted_page  = out_ev_page_q;
  assign rsp.fault_count   = out_fault_q;

  a_sos_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req.start_of_sequence |=> valid_vec == '0)
    else $error("frames not emptied at start of sequence");

  a_miss_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !acc.hit_found |=> rsp.valid && !rsp.hit && rsp.fault_count != '0)
    else $error("miss not reported as a fault");

  a_full_evicts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !acc.hit_found && LIM_W'(acc.used) >= limit |=> rsp.evicted_valid)
    else $error("miss on full frames did not evict");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.hit |-> !rsp.evicted_valid && rsp.evicted_page == '0)
    else $error("hit item reports an eviction");

endmodule
